// ----- hw/rtl/pfa_pkg.sv -----
// pfa_pkg: shared constants, codes and controller/datapath interface types
// for the partition fit allocator. No dependencies.
package pfa_pkg;

  localparam int unsigned MaxBlocksDef = 16;

  localparam int unsigned SizeW   = 16;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned BlocksW = 5;
  localparam int unsigned PolicyW = 2;
  localparam int unsigned CfgW    = 5;

  localparam logic [PolicyW-1:0] PolicyFirst = 2'd0;
  localparam logic [PolicyW-1:0] PolicyBest  = 2'd1;
  localparam logic [PolicyW-1:0] PolicyWorst = 2'd2;

  localparam logic RegFitPolicy = 1'b0;
  localparam logic RegBlocks    = 1'b1;

  localparam logic ActionLoad    = 1'b0;
  localparam logic ActionRequest = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic scan_start;
    logic scan_step;
    logic commit;
  } pfa_cmd_t;

  typedef struct packed {
    logic scan_end;
  } pfa_status_t;

endpackage

// ----- hw/rtl/pfa_ctrl.sv -----
// pfa_ctrl: sequencing state machine of the partition fit allocator.
// Depends on pfa_pkg for the command and status types.
module pfa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 action_i,
  input  logic                 out_free_i,
  input  pfa_pkg::pfa_status_t status_i,
  output pfa_pkg::pfa_cmd_t    cmd_o,
  output logic                 in_stall_o
);
  import pfa_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   accept;

  assign in_stall_o = stall_q;
  assign accept     = in_valid_i && !stall_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_wr    = (state_q == StIdle) && accept && (action_i == ActionLoad);
    cmd_o.scan_start = (state_q == StIdle) && accept && (action_i == ActionRequest);
    cmd_o.scan_step  = (state_q == StScan) && !status_i.scan_end;
    cmd_o.commit     = (state_q == StFinish) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stall_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && (action_i == ActionRequest)) begin
            state_q <= StScan;
            stall_q <= 1'b1;
          end
        end
        StScan: begin
          if (status_i.scan_end) begin
            state_q <= StFinish;
          end
        end
        StFinish: begin
          if (out_free_i) begin
            state_q <= StIdle;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= StIdle;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pfa_datapath.sv -----
// pfa_datapath: free space memory, scan counter and fit selection.
// Depends on pfa_pkg; driven by pfa_ctrl commands.
module pfa_datapath #(
  parameter int unsigned MaxBlocks = pfa_pkg::MaxBlocksDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfa_pkg::pfa_cmd_t          cmd_i,
  output pfa_pkg::pfa_status_t       status_o,
  input  logic [pfa_pkg::PolicyW-1:0] fit_policy_i,
  input  logic [pfa_pkg::BlocksW-1:0] blocks_in_use_i,
  input  logic [pfa_pkg::IndexW-1:0]  load_index_i,
  input  logic [pfa_pkg::SizeW-1:0]   load_size_i,
  input  logic [pfa_pkg::SizeW-1:0]   request_size_i,
  input  logic                        last_request_i,
  output logic                        found_o,
  output logic [pfa_pkg::IndexW-1:0]  chosen_index_o,
  output logic [pfa_pkg::SizeW-1:0]   space_left_o,
  output logic                        batch_end_o
);
  import pfa_pkg::*;

  localparam int unsigned AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned CntW  = $clog2(MaxBlocks + 1);
  localparam int unsigned LimW  = (CntW > BlocksW) ? CntW : BlocksW;
  localparam int unsigned LdW   = (CntW > IndexW) ? CntW : IndexW;
  localparam int unsigned PickW = (AddrW > IndexW) ? AddrW : IndexW;

  logic [SizeW-1:0] mem_q [MaxBlocks];
  logic [SizeW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_idx_q;
  logic             rd_vld_q;

  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  limit_q;
  logic [SizeW-1:0] req_q;
  logic             last_q;
  logic             have_q;
  logic [AddrW-1:0] pick_q;
  logic [SizeW-1:0] best_q;

  logic [LimW-1:0]  blocks_ext;
  logic [CntW-1:0]  limit_d;
  logic [LdW-1:0]   load_ext;
  logic             load_ok;
  logic             fits;
  logic             take;
  logic [SizeW-1:0] left;
  logic [PickW-1:0] pick_ext;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [SizeW-1:0] wr_data;

  always_comb begin
    blocks_ext = LimW'(blocks_in_use_i);
    if (blocks_ext > LimW'(MaxBlocks)) begin
      limit_d = CntW'(MaxBlocks);
    end else begin
      limit_d = CntW'(blocks_ext);
    end
    load_ext = LdW'(load_index_i);
    load_ok  = load_ext < LdW'(MaxBlocks);
  end

  always_comb begin
    fits = rd_vld_q && (rd_data_q >= req_q);
    take = fits && (!have_q
        || ((fit_policy_i == PolicyBest) && (rd_data_q < best_q))
        || ((fit_policy_i == PolicyWorst) && (rd_data_q > best_q)));
    left = best_q - req_q;
  end

  always_comb begin
    if (cmd_i.commit) begin
      wr_en   = have_q;
      wr_addr = pick_q;
      wr_data = left;
    end else begin
      wr_en   = cmd_i.load_wr && load_ok;
      wr_addr = load_ext[AddrW-1:0];
      wr_data = load_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.scan_step) begin
      rd_data_q <= mem_q[cnt_q[AddrW-1:0]];
      rd_idx_q  <= cnt_q[AddrW-1:0];
    end
    if (cmd_i.scan_start) begin
      req_q   <= request_size_i;
      last_q  <= last_request_i;
      limit_q <= limit_d;
    end
    if (take) begin
      pick_q <= rd_idx_q;
      best_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (take) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.scan_end = (cnt_q == limit_q);

  assign pick_ext       = PickW'(pick_q);
  assign found_o        = have_q;
  assign chosen_index_o = have_q ? pick_ext[IndexW-1:0] : '0;
  assign space_left_o   = have_q ? left : '0;
  assign batch_end_o    = last_q;

endmodule

// ----- hw/rtl/partition_fit_allocator.sv -----
// partition_fit_allocator: top level with configuration registers, output
// register and the controller/datapath pair. Depends on pfa_pkg, pfa_ctrl
// and pfa_datapath.
//
// Input channel (in_valid_i / in_stall_o) carries one word per item. A load
// word (action 0) writes one partition's free size without raising
// in_stall_o, producing no result. A request word (action 1) scans partitions
// 0 .. blocks_in_use-1 (at most MaxBlocks) one per cycle through the
// free space memory's single read port, then updates the chosen entry, if
// any, and loads the result word into the output register. in_stall_o stays
// high from acceptance until the result word is loaded, so no new word is
// taken while a request is in progress. A stalled output register delays that load.
// Output channel (out_valid_o / out_stall_i) holds one result word in a
// register. While it is stalled, load words are still accepted; a finished
// request waits until the register is free.
// Configuration: cfg_we_i writes cfg_wdata_i to fit_policy (index 0) or
// blocks_in_use (index 1); write only while idle.
// Reset clears the policy to first fit and blocks_in_use to 16. Free space
// entries are undefined until loaded.
module partition_fit_allocator #(
  parameter int unsigned MaxBlocks = pfa_pkg::MaxBlocksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [pfa_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [pfa_pkg::IndexW-1:0]   load_index_i,
  input  logic [pfa_pkg::SizeW-1:0]    load_size_i,
  input  logic [pfa_pkg::SizeW-1:0]    request_size_i,
  input  logic                         last_request_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [pfa_pkg::IndexW-1:0]   chosen_index_o,
  output logic [pfa_pkg::SizeW-1:0]    space_left_o,
  output logic                         batch_end_o
);
  import pfa_pkg::*;

  logic [PolicyW-1:0] fit_policy_q;
  logic [BlocksW-1:0] blocks_q;

  pfa_cmd_t    cmd;
  pfa_status_t status;
  logic        out_free;

  logic              dp_found;
  logic [IndexW-1:0] dp_index;
  logic [SizeW-1:0]  dp_left;
  logic              dp_last;

  logic              out_valid_q;
  logic              found_q;
  logic [IndexW-1:0] index_q;
  logic [SizeW-1:0]  left_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= PolicyFirst;
      blocks_q     <= BlocksW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFitPolicy: fit_policy_q <= cfg_wdata_i[PolicyW-1:0];
        RegBlocks:    blocks_q     <= cfg_wdata_i[BlocksW-1:0];
        default:      ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  pfa_datapath #(
    .MaxBlocks (MaxBlocks)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .fit_policy_i    (fit_policy_q),
    .blocks_in_use_i (blocks_q),
    .load_index_i    (load_index_i),
    .load_size_i     (load_size_i),
    .request_size_i  (request_size_i),
    .last_request_i  (last_request_i),
    .found_o         (dp_found),
    .chosen_index_o  (dp_index),
    .space_left_o    (dp_left),
    .batch_end_o     (dp_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      found_q <= dp_found;
      index_q <= dp_index;
      left_q  <= dp_left;
      last_q  <= dp_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign chosen_index_o = index_q;
  assign space_left_o   = left_q;
  assign batch_end_o    = last_q;

endmodule

// ----- tb/sv/partition_fit_checker.sv -----
// partition_fit_checker: watches the request, result and register ports of the
// partition fit allocator, predicts every result word and compares it.
// Depends on pfa_pkg.
module partition_fit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pfa_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [pfa_pkg::IndexW-1:0]    load_index_i,
  input  logic [pfa_pkg::SizeW-1:0]     load_size_i,
  input  logic [pfa_pkg::SizeW-1:0]     request_size_i,
  input  logic                          last_request_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          found_o,
  input  logic [pfa_pkg::IndexW-1:0]    chosen_index_o,
  input  logic [pfa_pkg::SizeW-1:0]     space_left_o,
  input  logic                          batch_end_o,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] index;
    logic [SizeW-1:0]  left;
    logic              batch_end;
  } alloc_word_t;

  logic [SizeW-1:0]   free_space [MaxBlocksDef];
  logic [PolicyW-1:0] fit_policy = PolicyFirst;
  logic [BlocksW-1:0] scan_blocks = BlocksW'(MaxBlocksDef);
  alloc_word_t        due_words [$];
  int unsigned        mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic alloc_word_t fit_request(input logic [SizeW-1:0] req, input logic last);
    alloc_word_t word;
    int unsigned scan_n;
    int          pick;
    int          j;
    scan_n = (scan_blocks > MaxBlocksDef) ? MaxBlocksDef : scan_blocks;
    pick = -1;
    for (j = 0; j < scan_n; j++) begin
      if (free_space[j] >= req) begin
        if (pick < 0) begin
          pick = j;
        end else if (fit_policy == PolicyBest && free_space[j] < free_space[pick]) begin
          pick = j;
        end else if (fit_policy == PolicyWorst && free_space[j] > free_space[pick]) begin
          pick = j;
        end
      end
    end
    word = '0;
    if (pick >= 0) begin
      free_space[pick] = free_space[pick] - req;
      word.found = 1'b1;
      word.index = IndexW'(pick);
      word.left = free_space[pick];
    end
    word.batch_end = last;
    return word;
  endfunction

  task automatic compare_field(input string name, input logic [SizeW-1:0] want,
                               input logic [SizeW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    alloc_word_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegFitPolicy) begin
          fit_policy = cfg_wdata_i[PolicyW-1:0];
        end else begin
          scan_blocks = cfg_wdata_i[BlocksW-1:0];
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $error("result word with no request outstanding");
          mismatches++;
        end else begin
          want = due_words.pop_front();
          compare_field("found", SizeW'(want.found), SizeW'(found_o));
          compare_field("chosen_index", SizeW'(want.index), SizeW'(chosen_index_o));
          compare_field("space_left", want.left, space_left_o);
          compare_field("batch_end", SizeW'(want.batch_end), SizeW'(batch_end_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (action_i == ActionLoad) begin
          free_space[load_index_i] = load_size_i;
        end else begin
          due_words.push_back(fit_request(request_size_i, last_request_i));
        end
      end
      results_due_o <= due_words.size();
    end
  end

endmodule

// ----- tb/sv/partition_fit_allocator_tb.sv -----
// partition_fit_allocator_tb: drives load and allocation words and register
// settings into the allocator under several idle and stall mixes and gives the
// verdict. Depends on pfa_pkg, partition_fit_allocator and partition_fit_checker.
module partition_fit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam logic [PolicyW-1:0] PolicySpare = 2'd3;
  localparam int unsigned PhaseCount = 8;
  localparam int unsigned PhaseItems = 190;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit = 500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = RegFitPolicy;
  logic [CfgW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ActionLoad;
  logic [IndexW-1:0] load_index = '0;
  logic [SizeW-1:0] load_size = '0;
  logic [SizeW-1:0] request_size = '0;
  logic last_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [IndexW-1:0] chosen_index;
  logic [SizeW-1:0] space_left;
  logic batch_end;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned loads_sent = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_used = 0;

  logic [SizeW-1:0] seed_sizes [16] = '{16'd100, 16'd0, 16'hFFFF, 16'd100, 16'd50, 16'd50,
                                       16'd7, 16'd7, 16'd300, 16'd300, 16'd1, 16'd2,
                                       16'd3, 16'd4, 16'd5, 16'd6};
  logic [PolicyW-1:0] phase_policy [PhaseCount] = '{PolicyFirst, PolicyBest, PolicyWorst,
                                                    PolicySpare, PolicyFirst, PolicyBest,
                                                    PolicyWorst, PolicySpare};
  logic [BlocksW-1:0] phase_blocks [PhaseCount] = '{5'd16, 5'd16, 5'd1, 5'd16, 5'd31,
                                                    5'd5, 5'd16, 5'd11};

  partition_fit_allocator uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .load_index_i   (load_index),
    .load_size_i    (load_size),
    .request_size_i (request_size),
    .last_request_i (last_request),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .chosen_index_o (chosen_index),
    .space_left_o   (space_left),
    .batch_end_o    (batch_end)
  );

  partition_fit_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .load_index_i     (load_index),
    .load_size_i      (load_size),
    .request_size_i   (request_size),
    .last_request_i   (last_request),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .found_o          (found),
    .chosen_index_o   (chosen_index),
    .space_left_o     (space_left),
    .batch_end_o      (batch_end),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("partition_fit_allocator verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic act, input logic [IndexW-1:0] idx,
                           input logic [SizeW-1:0] lsize, input logic [SizeW-1:0] rsize,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    load_index <= idx;
    load_size <= lsize;
    request_size <= rsize;
    last_request <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ActionLoad) begin
      loads_sent++;
    end else begin
      requests_sent++;
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [PolicyW-1:0] policy, input logic [BlocksW-1:0] blocks);
    hold_until_drained();
    cfg_we <= 1'b1;
    cfg_idx <= RegFitPolicy;
    cfg_wdata <= {(CfgW-PolicyW)'($urandom_range(7)), policy};
    @(posedge clk);
    cfg_idx <= RegBlocks;
    cfg_wdata <= blocks;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random();
    logic act;
    logic [SizeW-1:0] lsize;
    logic [SizeW-1:0] rsize;
    act = ($urandom_range(99) < 45) ? ActionLoad : ActionRequest;
    case ($urandom_range(9))
      0: lsize = '0;
      1: lsize = '1;
      2, 3: lsize = SizeW'($urandom_range(15));
      4, 5, 6: lsize = SizeW'($urandom_range(1023));
      default: lsize = SizeW'($urandom);
    endcase
    case ($urandom_range(9))
      0: rsize = '0;
      1: rsize = '1;
      2, 3, 4: rsize = SizeW'($urandom_range(15));
      5, 6, 7: rsize = SizeW'($urandom_range(511));
      default: rsize = SizeW'($urandom);
    endcase
    send_word(act, IndexW'($urandom_range(15)), lsize, rsize, $urandom_range(3) == 0);
  endtask

  initial begin : stimulus
    int i;
    int p;
    int n;
    int mode;
    int pause_at;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every partition so no scan touches an unloaded entry
    for (i = 0; i < 16; i++) begin
      send_word(ActionLoad, IndexW'(i), seed_sizes[i], SizeW'($urandom), 1'b0);
    end
    send_word(ActionRequest, '1, '1, 16'd0, 1'b0);
    send_word(ActionRequest, '0, '0, 16'hFFFF, 1'b1);
    send_word(ActionRequest, '0, '0, 16'hFFFF, 1'b0);
    set_config(PolicyBest, 5'd16);
    send_word(ActionRequest, '0, '0, 16'd40, 1'b0);
    set_config(PolicyWorst, 5'd16);
    send_word(ActionRequest, '0, '0, 16'd10, 1'b1);
    set_config(PolicySpare, 5'd16);
    send_word(ActionRequest, '0, '0, 16'd5, 1'b0);
    set_config(PolicyFirst, 5'd0);
    send_word(ActionRequest, '0, '0, 16'd0, 1'b1);
    set_config(PolicyWorst, 5'd31);
    send_word(ActionRequest, '0, '0, 16'd1, 1'b0);
    set_config(PolicyBest, 5'd1);
    send_word(ActionRequest, '0, '0, 16'd96, 1'b1);

    for (p = 0; p < PhaseCount; p++) begin
      set_config(phase_policy[p], phase_blocks[p]);
      mode = (p + p / 4) % 4;
      send_idle_pct = (mode == 1) ? 66 : (mode == 3) ? 30 : 0;
      stall_pct = (mode == 2) ? 66 : (mode == 3) ? 30 : 0;
      pause_at = $urandom_range(PhaseItems - 1);
      for (n = 0; n < PhaseItems; n++) begin
        if (n == pause_at) begin
          hold_until_drained();
        end
        send_random();
      end
    end

    hold_until_drained();
    $display("sent %0d load words and %0d allocation requests over %0d register settings",
             loads_sent, requests_sent, settings_used);
    $display("all fit policies incl. the spare code, scan counts 0 to 31, idle/stall mixes");
    if (mismatches == 0) begin
      $display("partition_fit_allocator verification clean");
    end else begin
      $display("partition_fit_allocator verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/pfa_datapath.sv
hw/rtl/partition_fit_allocator.sv
tb/sv/partition_fit_checker.sv
tb/sv/partition_fit_allocator_tb.sv
